// ----- rtl/core/gatl_pkg.sv -----
// Shared types, constants and helpers for the glyph advance text layout block.
package gatl_pkg;

  // Font and map sizes
  localparam int GLYPH_SLOTS = 256;
  localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
  localparam int MAP_ENTRIES = 256;
  localparam int MAP_W       = $clog2(MAP_ENTRIES);

  localparam logic [7:0] UNMAPPED     = 8'hFF;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // Rounded step widths: |metric * scale| < 2^31
  localparam int PROD_W = 33;
  localparam int STEP_W = PROD_W - 12;
  localparam int OFF_W  = PROD_W - 13;

  // Output queue
  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;
  localparam int OCC_W      = OUTQ_CNT_W + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_ADVANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd4;

  localparam logic [15:0] SCALE_RESET    = 16'd4096;
  localparam logic [19:0] LINE_ADV_RESET = 20'd1024;

  // Result kinds
  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_WIDTH = 1'b1;

  typedef enum logic [1:0] {
    FN_LOAD_MAP,
    FN_LOAD_METRICS,
    FN_CHAR,
    FN_END
  } func_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_GLYPH,
    OP_NEWLINE,
    OP_END
  } op_t;

  typedef struct packed {
    func_t              func;
    logic [7:0]         char_code;
    logic [7:0]         glyph_index;
    logic signed [15:0] glyph_advance;
    logic signed [15:0] glyph_adjust;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [7:0]         placed_char;
    logic [30:0]        text_width;
  } out_t;

  // Request moving down the arithmetic stages
  typedef struct packed {
    logic       v;
    op_t        op;
    logic [7:0] code;
  } stage_t;

  function automatic logic slot_ok(input logic [7:0] slot);
    logic [8:0] lim;
    lim = 9'(GLYPH_SLOTS);
    return ({1'b0, slot} < lim);
  endfunction

  function automatic logic glyph_ok(input logic [7:0] g);
    return (g != UNMAPPED) && slot_ok(g);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] sum;
    sum = {a[31], a} + {b[31], b};
    if (sum[32] != sum[31]) begin
      return sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
    return sum[31:0];
  endfunction

endpackage

// ----- rtl/core/gatl_charmap.sv -----
// Character-to-glyph map: synchronous memory plus per-entry valid bits.
module gatl_charmap (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [gatl_pkg::MAP_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic [gatl_pkg::MAP_W-1:0] rd_addr,
  output logic [7:0]                rd_glyph
);

  logic [7:0] mem [gatl_pkg::MAP_ENTRIES];
  logic [gatl_pkg::MAP_ENTRIES-1:0] vld;
  logic [7:0] rd_q;
  logic       rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // never-written entries read as unmapped
  assign rd_glyph = rd_vld ? rd_q : gatl_pkg::UNMAPPED;

endmodule

// ----- rtl/core/gatl_metrics.sv -----
// Glyph metrics store: one write and one registered read per cycle.
module gatl_metrics (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [gatl_pkg::SLOT_W-1:0] wr_addr,
  input  logic [31:0]                wr_data,
  input  logic [gatl_pkg::SLOT_W-1:0] rd_addr,
  output logic [31:0]                rd_data
);

  logic [31:0] mem [gatl_pkg::GLYPH_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/gatl_pen.sv -----
// Scaling, rounding and the pen accumulator stage.
module gatl_pen (
  input  logic                    clk,
  input  logic                    rst,
  input  gatl_pkg::stage_t        s2,
  input  logic [31:0]             metrics,
  input  logic [15:0]             scale,
  input  logic [19:0]             line_advance,
  input  logic                    alt_mode,
  input  logic signed [31:0]      origin_x,
  input  logic signed [31:0]      origin_y,
  output logic                    push,
  output gatl_pkg::out_t          result,
  output logic [1:0]              inflight
);

  localparam int PW = gatl_pkg::PROD_W;

  // products
  gatl_pkg::stage_t         s3;
  logic signed [PW-1:0]     prod_adv;
  logic signed [PW-1:0]     prod_adj;
  logic signed [PW-1:0]     mul_adv;
  logic signed [PW-1:0]     mul_adj;

  // rounded steps
  gatl_pkg::stage_t                      s4;
  logic signed [gatl_pkg::STEP_W-1:0]    step_adv;
  logic signed [gatl_pkg::STEP_W-1:0]    step_adj;
  logic signed [gatl_pkg::OFF_W-1:0]     off;
  logic signed [PW-1:0]                  sum_adv12;
  logic signed [PW-1:0]                  sum_adj12;
  logic signed [PW-1:0]                  sum_adj13;
  logic signed [gatl_pkg::STEP_W-1:0]    step_adj_sel;
  logic signed [gatl_pkg::OFF_W-1:0]     off_sel;

  // pen state
  logic signed [31:0] pen_x;
  logic signed [31:0] pen_y;
  logic [30:0]        widest;
  logic signed [31:0] pen_x_next;
  logic signed [31:0] pen_y_next;
  logic [30:0]        widest_next;
  logic               line_wider;

  assign mul_adv = $signed(metrics[15:0])  * $signed({1'b0, scale});
  assign mul_adj = $signed(metrics[31:16]) * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else begin
      s3 <= s2;
    end
    prod_adv <= mul_adv;
    prod_adj <= mul_adj;
  end

  // round to nearest, halves up: add half then drop the fraction bits
  always_comb begin
    sum_adv12    = prod_adv + PW'(2048);
    sum_adj12    = prod_adj + PW'(2048);
    sum_adj13    = prod_adj + PW'(4096);
    step_adj_sel = alt_mode ? sum_adj12[PW-1:12] : '0;
    off_sel      = alt_mode ? sum_adj13[PW-1:13] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4 <= '0;
    end else begin
      s4 <= s3;
    end
    step_adv <= sum_adv12[PW-1:12];
    step_adj <= step_adj_sel;
    off      <= off_sel;
  end

  assign line_wider = $signed(pen_x) > $signed({1'b0, widest});

  always_comb begin
    pen_x_next  = pen_x;
    pen_y_next  = pen_y;
    widest_next = widest;
    push        = 1'b0;
    result      = '0;
    if (s4.v) begin
      case (s4.op)
        gatl_pkg::OP_GLYPH: begin
          push               = 1'b1;
          result.result_kind = gatl_pkg::KIND_PLACE;
          result.pos_x       = gatl_pkg::sat_add(gatl_pkg::sat_add(origin_x, pen_x),
                                                 32'(off));
          result.pos_y       = gatl_pkg::sat_add(origin_y, pen_y);
          result.placed_char = s4.code;
          pen_x_next         = gatl_pkg::sat_add(gatl_pkg::sat_add(pen_x, 32'(step_adv)),
                                                 32'(step_adj));
        end
        gatl_pkg::OP_NEWLINE: begin
          if (line_wider) begin
            widest_next = pen_x[30:0];
          end
          pen_x_next = '0;
          pen_y_next = gatl_pkg::sat_add(pen_y, $signed({12'd0, line_advance}));
        end
        gatl_pkg::OP_END: begin
          push               = 1'b1;
          result.result_kind = gatl_pkg::KIND_WIDTH;
          result.text_width  = line_wider ? pen_x[30:0] : widest;
          pen_x_next         = '0;
          pen_y_next         = '0;
          widest_next        = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x  <= '0;
      pen_y  <= '0;
      widest <= '0;
    end else begin
      pen_x  <= pen_x_next;
      pen_y  <= pen_y_next;
      widest <= widest_next;
    end
  end

  assign inflight = {1'b0, s3.v} + {1'b0, s4.v};

endmodule

// ----- rtl/core/gatl_outq.sv -----
// Output queue: small register FIFO between the pen stage and the result port.
module gatl_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  gatl_pkg::out_t                  push_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gatl_pkg::out_t                  out_data,
  output logic [gatl_pkg::OUTQ_CNT_W-1:0] cnt
);

  gatl_pkg::out_t                  mem [gatl_pkg::OUTQ_DEPTH];
  logic [gatl_pkg::OUTQ_PTR_W-1:0] wr_ptr;
  logic [gatl_pkg::OUTQ_PTR_W-1:0] rd_ptr;
  logic                            pop;

  assign out_valid = (cnt != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- rtl/core/glyph_advance_text_layout.sv -----
// Top level of the glyph advance text layout block.
//
// Takes one request per clock while in_stall is low: map loads, metrics loads,
// characters and end-of-text markers, fully pipelined with no bubbles between
// back-to-back requests. A request goes through five stages: charmap read, metrics
// read/write, two scale multipliers, rounding, then the pen accumulator, whose
// saturating adds close the only cycle-to-cycle loop. A placement or width report
// is pushed from the pen stage into an 8-entry output queue that drives out_data;
// in_stall rises once queued results plus requests still in the pipeline reach that
// depth, so a stalled consumer throttles the input without freezing the memories.
// Both memories are synchronous with registered reads; the charmap keeps one valid bit
// per entry so it comes out of reset fully unmapped with no clearing pass, and the
// metrics store holds garbage until written. Stage order makes every load visible to
// the very next character, so no forwarding is needed. Configuration writes are
// always taken (cfg_ready is tied high) and must only happen while the block is idle.
module glyph_advance_text_layout (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gatl_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gatl_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gatl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);

  // configuration registers
  logic [15:0]        scale;
  logic [19:0]        line_advance;
  logic               alt_mode;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;

  // stage 1: charmap read data is valid here
  logic                s1_v;
  gatl_pkg::in_t       s1_req;
  logic [7:0]          glyph;
  gatl_pkg::op_t       s1_op;

  // stage 2: metrics read data is valid here
  gatl_pkg::stage_t    s2;
  logic [31:0]         metrics;

  logic                met_wr_en;
  logic                map_wr_en;
  logic                in_accept;

  logic                                push;
  gatl_pkg::out_t                      result;
  logic [1:0]                          inflight;
  logic [gatl_pkg::OUTQ_CNT_W-1:0]     q_cnt;
  logic [gatl_pkg::OCC_W-1:0]          occ;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= gatl_pkg::SCALE_RESET;
      line_advance <= gatl_pkg::LINE_ADV_RESET;
      alt_mode     <= 1'b0;
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gatl_pkg::CFG_SCALE:        scale        <= cfg_data[15:0];
        gatl_pkg::CFG_LINE_ADVANCE: line_advance <= cfg_data[19:0];
        gatl_pkg::CFG_ALT_MODE:     alt_mode     <= cfg_data[0];
        gatl_pkg::CFG_ORIGIN_X:     origin_x     <= $signed(cfg_data);
        gatl_pkg::CFG_ORIGIN_Y:     origin_y     <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Credit check: every request in flight has a queue slot reserved.
  assign occ       = gatl_pkg::OCC_W'(q_cnt) + gatl_pkg::OCC_W'(s1_v)
                   + gatl_pkg::OCC_W'(s2.v) + gatl_pkg::OCC_W'(inflight);
  assign in_stall  = (occ >= gatl_pkg::OCC_W'(gatl_pkg::OUTQ_DEPTH));
  assign in_accept = in_valid && !in_stall;

  // Stage 0: map writes and the lookup for characters share the same address.
  assign map_wr_en = in_accept && (in_data.func == gatl_pkg::FN_LOAD_MAP);

  gatl_charmap u_charmap (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (map_wr_en),
    .wr_addr  (in_data.char_code[gatl_pkg::MAP_W-1:0]),
    .wr_data  (in_data.glyph_index),
    .rd_addr  (in_data.char_code[gatl_pkg::MAP_W-1:0]),
    .rd_glyph (glyph)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_accept;
    end
    if (in_accept) begin
      s1_req <= in_data;
    end
  end

  // Stage 1: classify the request once the glyph is known.
  // Newline wins over any mapping of byte 10.
  always_comb begin
    case (s1_req.func)
      gatl_pkg::FN_CHAR: begin
        if (s1_req.char_code == gatl_pkg::NEWLINE_CODE) begin
          s1_op = gatl_pkg::OP_NEWLINE;
        end else if (gatl_pkg::glyph_ok(glyph)) begin
          s1_op = gatl_pkg::OP_GLYPH;
        end else begin
          s1_op = gatl_pkg::OP_NONE;
        end
      end
      gatl_pkg::FN_END: s1_op = gatl_pkg::OP_END;
      default:          s1_op = gatl_pkg::OP_NONE;
    endcase
  end

  // Metrics loads write in this stage, so a following character reads them.
  assign met_wr_en = s1_v && (s1_req.func == gatl_pkg::FN_LOAD_METRICS)
                   && gatl_pkg::slot_ok(s1_req.glyph_index);

  gatl_metrics u_metrics (
    .clk     (clk),
    .wr_en   (met_wr_en),
    .wr_addr (s1_req.glyph_index[gatl_pkg::SLOT_W-1:0]),
    .wr_data ({s1_req.glyph_adjust, s1_req.glyph_advance}),
    .rd_addr (glyph[gatl_pkg::SLOT_W-1:0]),
    .rd_data (metrics)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2.v    <= s1_v;
      s2.op   <= s1_op;
      s2.code <= s1_req.char_code;
    end
  end

  // Stages 2 to 4: scale, round, and the pen accumulator.
  gatl_pen u_pen (
    .clk          (clk),
    .rst          (rst),
    .s2           (s2),
    .metrics      (metrics),
    .scale        (scale),
    .line_advance (line_advance),
    .alt_mode     (alt_mode),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .push         (push),
    .result       (result),
    .inflight     (inflight)
  );

  gatl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cnt       (q_cnt)
  );

  // The credit scheme must never let the queue overflow.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= gatl_pkg::OCC_W'(gatl_pkg::OUTQ_DEPTH))
    else $error("output queue credit overrun");

  // An accepted request always enters the pipeline.
  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_v)
    else $error("accepted request lost before stage 1");

  // Pipeline never drops a request between the two memory stages.
  a_s1_s2: assert property (@(posedge clk) disable iff (rst)
    s1_v |=> s2.v)
    else $error("request lost between stage 1 and stage 2");

  // No result pushed while the queue is full and not draining.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q_cnt == gatl_pkg::OUTQ_CNT_W'(gatl_pkg::OUTQ_DEPTH)) && out_stall |-> !push)
    else $error("push into a full output queue");

endmodule

// ----- tb/sv/tb_glyph_advance_text_layout.sv -----
// Self-checking testbench for the glyph advance text layout block.
module tb_glyph_advance_text_layout;
  import gatl_pkg::*;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // DUT ports; every input starts at a known value
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCALE;
  logic [31:0]          cfg_data  = '0;

  glyph_advance_text_layout u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Requests waiting to be driven, and results the layout predictor still owes
  in_t  text_stream[$];
  out_t layout_results_due[$];
  int   layout_errs       = 0;
  int   cfg_writes_done   = 0;

  // Idle rates in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Layout predictor: its own copy of the font tables, pen and registers.
  // Pen values are kept in 64 bits and clamped to 32 after every add.
  // ---------------------------------------------------------------------------
  logic [7:0]         glyph_of [MAP_ENTRIES];
  logic signed [15:0] adv_of   [GLYPH_SLOTS];
  logic signed [15:0] adj_of   [GLYPH_SLOTS];
  longint             pen_x_q  = 0;
  longint             pen_y_q  = 0;
  longint             widest_q = 0;

  logic [15:0]        lay_scale    = SCALE_RESET;
  logic [19:0]        lay_line_adv = LINE_ADV_RESET;
  logic               lay_alt      = 1'b0;
  logic signed [31:0] lay_org_x    = '0;
  logic signed [31:0] lay_org_y    = '0;

  // Charmap comes out of reset all unmapped; metrics stay unknown and are
  // never read before they are loaded.
  initial begin
    foreach (glyph_of[i]) glyph_of[i] = UNMAPPED;
  end

  function automatic longint clamp32(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Nearest rounding with halves going up: floor((prod + half) / 2^sh)
  function automatic longint round_down_shift(longint prod, int sh);
    return (prod + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic void close_line();
    if (pen_x_q > widest_q) widest_q = pen_x_q;
  endfunction

  // Returns 1 when the request produces a result, filled into res.
  function automatic bit layout_predict(in_t req, output out_t res);
    logic [7:0] g;
    longint     adv, adj, scl, off;
    res = '0;
    case (req.func)
      FN_LOAD_MAP: begin
        glyph_of[req.char_code] = req.glyph_index;
        return 1'b0;
      end
      FN_LOAD_METRICS: begin
        if (int'(req.glyph_index) < GLYPH_SLOTS) begin
          adv_of[req.glyph_index] = req.glyph_advance;
          adj_of[req.glyph_index] = req.glyph_adjust;
        end
        return 1'b0;
      end
      FN_END: begin
        close_line();
        res.result_kind = KIND_WIDTH;
        res.text_width  = 31'(widest_q);
        pen_x_q  = 0;
        pen_y_q  = 0;
        widest_q = 0;
        return 1'b1;
      end
      default: begin
        // Byte 10 is a newline whatever the charmap says
        if (req.char_code == NEWLINE_CODE) begin
          close_line();
          pen_x_q = 0;
          pen_y_q = clamp32(pen_y_q + longint'(lay_line_adv));
          return 1'b0;
        end
        g = glyph_of[req.char_code];
        if (g == UNMAPPED || int'(g) >= GLYPH_SLOTS) return 1'b0;
        adv = longint'(adv_of[g]);
        adj = longint'(adj_of[g]);
        scl = longint'(lay_scale);
        off = lay_alt ? round_down_shift(adj * scl, 13) : 0;
        res.result_kind = KIND_PLACE;
        res.pos_x       = 32'(clamp32(clamp32(longint'(lay_org_x) + pen_x_q) + off));
        res.pos_y       = 32'(clamp32(longint'(lay_org_y) + pen_y_q));
        res.placed_char = req.char_code;
        pen_x_q = clamp32(pen_x_q + round_down_shift(adv * scl, 12));
        if (lay_alt) pen_x_q = clamp32(pen_x_q + round_down_shift(adj * scl, 12));
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: presents the next queued request once the current one
  // is taken. Predictions happen at the accepting edge, in stream order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t due;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (layout_predict(in_data, due)) layout_results_due.push_back(due);
      end
      // Only move on when nothing is held; a stalled request stays put
      if (!in_valid || !in_stall) begin
        if (text_stream.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= text_stream.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random backpressure, in-order compare against predictions.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (layout_results_due.size() == 0) begin
          layout_errs++;
          if (layout_errs <= 10)
            $display("unexpected result: kind %0d x %0d y %0d char %0d width %0d",
                     out_data.result_kind, out_data.pos_x, out_data.pos_y,
                     out_data.placed_char, out_data.text_width);
        end else begin
          want = layout_results_due.pop_front();
          if (out_data.result_kind !== want.result_kind ||
              out_data.pos_x !== want.pos_x || out_data.pos_y !== want.pos_y ||
              out_data.placed_char !== want.placed_char ||
              out_data.text_width !== want.text_width) begin
            layout_errs++;
            if (layout_errs <= 10)
              $display("mismatch: exp kind %0d x %0d y %0d char %0d width %0d / got kind %0d x %0d y %0d char %0d width %0d",
                       want.result_kind, want.pos_x, want.pos_y, want.placed_char,
                       want.text_width, out_data.result_kind, out_data.pos_x,
                       out_data.pos_y, out_data.placed_char, out_data.text_width);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Register writes land in the predictor at the edge that takes them.
  // Writes only happen with the pipeline empty, so no request sees a half update.
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE:        lay_scale    = cfg_data[15:0];
        CFG_LINE_ADVANCE: lay_line_adv = cfg_data[19:0];
        CFG_ALT_MODE:     lay_alt      = cfg_data[0];
        CFG_ORIGIN_X:     lay_org_x    = cfg_data;
        CFG_ORIGIN_Y:     lay_org_y    = cfg_data;
        default: ;
      endcase
      cfg_writes_done++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus bookkeeping: which slots hold metrics, which codes were mapped.
  // Map loads only ever point at loaded slots, so no unwritten metric is read.
  // ---------------------------------------------------------------------------
  bit         slot_loaded [GLYPH_SLOTS];
  int         loaded_slots[$];
  logic [7:0] mapped_codes[$];

  function automatic void push_req(func_t f, logic [7:0] code, logic [7:0] slot,
                                   logic signed [15:0] adv, logic signed [15:0] adj);
    in_t r;
    r.func          = f;
    r.char_code     = code;
    r.glyph_index   = slot;
    r.glyph_advance = adv;
    r.glyph_adjust  = adj;
    if (f == FN_LOAD_METRICS && int'(slot) < GLYPH_SLOTS && !slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(int'(slot));
    end
    if (f == FN_LOAD_MAP && slot != UNMAPPED) mapped_codes.push_back(code);
    text_stream.push_back(r);
  endfunction

  // Metric values lean on the extremes and on small positive advances
  function automatic logic signed [15:0] pick_metric();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      4, 5, 6: return 16'($urandom_range(0, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random text: mostly mapped characters, with loads, newlines, ends and
  // stray bytes mixed in. Unused fields carry random junk.
  task automatic gen_text(int n);
    for (int i = 0; i < n; i++) begin
      int                 r;
      logic [7:0]         slot;
      logic [7:0]         junk_idx;
      logic signed [15:0] junk_a, junk_b;
      r        = $urandom_range(0, 99);
      junk_idx = 8'($urandom);
      junk_a   = 16'($urandom);
      junk_b   = 16'($urandom);
      if (r < 7) begin
        push_req(FN_LOAD_METRICS, 8'($urandom), 8'($urandom), pick_metric(), pick_metric());
      end else if (r < 14) begin
        if (loaded_slots.size() == 0 || $urandom_range(0, 6) == 0)
          slot = UNMAPPED;
        else
          slot = 8'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
        push_req(FN_LOAD_MAP, 8'($urandom), slot, junk_a, junk_b);
      end else if (r < 18) begin
        push_req(FN_END, 8'($urandom), junk_idx, junk_a, junk_b);
      end else if (r < 24) begin
        push_req(FN_CHAR, NEWLINE_CODE, junk_idx, junk_a, junk_b);
      end else if (r < 30 || mapped_codes.size() == 0) begin
        push_req(FN_CHAR, 8'($urandom), junk_idx, junk_a, junk_b);
      end else begin
        push_req(FN_CHAR, mapped_codes[$urandom_range(0, mapped_codes.size() - 1)],
                 junk_idx, junk_a, junk_b);
      end
    end
  endtask

  // Wait until every queued request is taken and every result is back,
  // then let the pipeline settle (loads produce no result to wait on).
  task automatic drain(int settle);
    do @(posedge clk);
    while (text_stream.size() != 0 || in_valid || layout_results_due.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    int seen;
    @(posedge clk);
    seen = cfg_writes_done;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    wait (cfg_writes_done != seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] scl, logic [31:0] ladv, logic [31:0] alt,
                           logic [31:0] ox, logic [31:0] oy);
    write_reg(CFG_SCALE, scl);
    write_reg(CFG_LINE_ADVANCE, ladv);
    write_reg(CFG_ALT_MODE, alt);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
  endtask

  // Origins: mostly modest, sometimes anywhere in the 32-bit range
  function automatic logic [31:0] pick_origin();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 200000)) - 100000);
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Phase 0: reset register values, sender idles a little, receiver a lot
    send_idle_pct  = 10;
    recv_stall_pct = 55;

    // Directed text: metric extremes, every request kind, newline even when
    // mapped, unmapped and never-mapped bytes, a negative line, empty text.
    push_req(FN_LOAD_METRICS, 8'h00, 8'd0,   16'sh7fff, 16'sh8000);
    push_req(FN_LOAD_METRICS, 8'hff, 8'd1,   16'sh8000, 16'sh7fff);
    push_req(FN_LOAD_METRICS, 8'h55, 8'd254, 16'sd640,  16'sd128);
    push_req(FN_LOAD_METRICS, 8'haa, 8'd255, 16'sd1,    -16'sd1);
    push_req(FN_LOAD_MAP, 8'd65,  8'd1,   16'sh7fff, 16'sh8000);
    push_req(FN_LOAD_MAP, 8'd66,  8'd0,   '0, '0);
    push_req(FN_LOAD_MAP, 8'd255, 8'd254, '0, '0);
    push_req(FN_LOAD_MAP, 8'd0,   UNMAPPED, '0, '0);
    push_req(FN_LOAD_MAP, NEWLINE_CODE, 8'd254, '0, '0);
    push_req(FN_CHAR, 8'd66,  8'hff, 16'sh7fff, 16'sh8000);
    push_req(FN_CHAR, 8'd255, 8'h00, '0, '0);
    push_req(FN_CHAR, 8'd0,   8'h00, '0, '0);          // explicitly unmapped
    push_req(FN_CHAR, 8'd122, 8'h00, '0, '0);          // never mapped
    push_req(FN_CHAR, NEWLINE_CODE, 8'h00, '0, '0);    // mapped, still a newline
    push_req(FN_CHAR, 8'd65,  8'h00, '0, '0);          // pen goes negative
    push_req(FN_CHAR, NEWLINE_CODE, 8'h00, '0, '0);    // negative line, widest kept
    push_req(FN_CHAR, 8'd65,  8'h00, '0, '0);
    push_req(FN_END,  8'hff,  8'hff, 16'sh7fff, 16'sh8000);
    push_req(FN_END,  8'h00,  8'h00, '0, '0);          // empty text reports zero
    push_req(FN_LOAD_MAP, 8'd66, UNMAPPED, '0, '0);    // remap back to unmapped
    push_req(FN_CHAR, 8'd66,  8'h00, '0, '0);
    push_req(FN_CHAR, 8'd255, 8'h00, '0, '0);
    push_req(FN_END,  8'h00,  8'h00, '0, '0);
    gen_text(210);
    drain(12);

    // Phase 1: largest scale and line advance, origin x at its top and y at its bottom;
    // the sender holds off mid-phase until the block has handed back every pending result.
    write_all(32'h0000_ffff, 32'h000f_ffff, 32'd1, 32'h7fff_ffff, 32'h8000_0000);
    gen_text(110);
    drain(0);
    gen_text(110);
    drain(12);

    // Phase 2: zero scale and line advance, origins at the opposite extremes, idle rates swapped
    send_idle_pct  = 55;
    recv_stall_pct = 10;
    write_all(32'h0000_0000, 32'h0000_0000, 32'd1, 32'h8000_0000, 32'h7fff_ffff);
    gen_text(250);
    drain(12);

    // Phases 3-5: random settings, junk in the unused upper data bits
    for (int p = 3; p < 6; p++) begin
      if (p >= 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_all($urandom, $urandom, $urandom, pick_origin(), pick_origin());
      gen_text(250);
      drain(12);
    end

    drain(20);
    if (layout_errs == 0 && layout_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
